/* rtl/nps_pkg.sv */
// Package for the non-preemptive priority scheduler.
// Holds widths, capacity and the controller/datapath command and status types.
// No dependencies.
package nps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam int BURST_W   = 16;
    localparam int ARR_W     = 16;
    localparam int PRIO_W    = 8;
    localparam int JOB_IDX_W = 6;
    localparam int TICK_W    = 23;
    localparam int SUM_W     = 29;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic jump;
        logic commit1;
        logic commit2;
        logic commit3;
        logic clear;
    } nps_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic final_job;
    } nps_status_t;

endpackage

/* rtl/nps_job_if.sv */
// Request channel carrying one job into the scheduler.
// Depends on nps_pkg for field widths.
interface nps_job_if;
    logic                        valid;
    logic                        ready;
    logic [nps_pkg::BURST_W-1:0] burst_time;
    logic [nps_pkg::ARR_W-1:0]   arrival_time;
    logic [nps_pkg::PRIO_W-1:0]  priority_level;
    logic                        last;

    modport source (output valid, burst_time, arrival_time, priority_level, last,
                    input ready);
    modport sink   (input valid, burst_time, arrival_time, priority_level, last,
                    output ready);
endinterface

/* rtl/nps_res_if.sv */
// Request channel carrying one schedule result out of the scheduler.
// Depends on nps_pkg for field widths.
interface nps_res_if;
    logic                          valid;
    logic                          ready;
    logic [nps_pkg::JOB_IDX_W-1:0] job_index;
    logic [nps_pkg::TICK_W-1:0]    wait_time;
    logic [nps_pkg::TICK_W-1:0]    turnaround_time;
    logic [nps_pkg::SUM_W-1:0]     wait_sum;
    logic [nps_pkg::SUM_W-1:0]     turnaround_sum;
    logic                          overflow;
    logic                          last_result;

    modport source (output valid, job_index, wait_time, turnaround_time, wait_sum,
                           turnaround_sum, overflow, last_result,
                    input ready);
    modport sink   (input valid, job_index, wait_time, turnaround_time, wait_sum,
                          turnaround_sum, overflow, last_result,
                    output ready);
endinterface

/* rtl/nps_ctrl.sv */
// Scheduler controller: sequences load, selection scans, commit and output.
// Depends on nps_pkg (command and status types).
module nps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  nps_pkg::nps_status_t status,
    output nps_pkg::nps_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_C1,
        S_C2,
        S_C3,
        S_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.found)
                    state_next = S_C1;
                else
                begin
                    // nothing arrived yet: jump to earliest arrival and pick again
                    cmd.jump   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_C1:
            begin
                cmd.commit1 = 1'b1;
                state_next  = S_C2;
            end
            S_C2:
            begin
                cmd.commit2 = 1'b1;
                state_next  = S_C3;
            end
            S_C3:
            begin
                cmd.commit3 = 1'b1;
                state_next  = S_SEND;
            end
            S_SEND:
            begin
                if (out_ready)
                begin
                    if (status.final_job)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == S_IDLE);
            out_valid_reg <= (state_next == S_SEND);
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

/* rtl/nps_datapath.sv */
// Scheduler datapath: job stores, pending flags, sequential selection scan,
// tick and sum arithmetic, result registers. Depends on nps_pkg.
module nps_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nps_pkg::nps_cmd_t             cmd,
    output nps_pkg::nps_status_t          status,
    input  logic [nps_pkg::BURST_W-1:0]   burst_time,
    input  logic [nps_pkg::ARR_W-1:0]     arrival_time,
    input  logic [nps_pkg::PRIO_W-1:0]    priority_level,
    output logic [nps_pkg::JOB_IDX_W-1:0] job_index,
    output logic [nps_pkg::TICK_W-1:0]    wait_time,
    output logic [nps_pkg::TICK_W-1:0]    turnaround_time,
    output logic [nps_pkg::SUM_W-1:0]     wait_sum,
    output logic [nps_pkg::SUM_W-1:0]     turnaround_sum,
    output logic                          overflow,
    output logic                          last_result
);

    logic [nps_pkg::BURST_W-1:0] burst_store_reg    [nps_pkg::MAX_PROCS];
    logic [nps_pkg::ARR_W-1:0]   arrival_store_reg  [nps_pkg::MAX_PROCS];
    logic [nps_pkg::PRIO_W-1:0]  priority_store_reg [nps_pkg::MAX_PROCS];

    logic [nps_pkg::MAX_PROCS-1:0] pend_reg;
    logic [nps_pkg::CNT_W-1:0]     count_reg;
    logic [nps_pkg::CNT_W-1:0]     done_reg;
    logic [nps_pkg::TICK_W-1:0]    tick_reg;
    logic [nps_pkg::SUM_W-1:0]     wsum_reg;
    logic [nps_pkg::SUM_W-1:0]     tsum_reg;
    logic                          drop_reg;
    logic [nps_pkg::IDX_W-1:0]     k_reg;
    logic                          found_reg;
    logic                          any_reg;
    logic [nps_pkg::ARR_W-1:0]     earliest_reg;

    logic [nps_pkg::IDX_W-1:0]     best_idx_reg;
    logic [nps_pkg::PRIO_W-1:0]    best_prio_reg;
    logic [nps_pkg::ARR_W-1:0]     best_arr_reg;
    logic [nps_pkg::BURST_W-1:0]   best_burst_reg;

    logic [nps_pkg::JOB_IDX_W-1:0] res_idx_reg;
    logic [nps_pkg::TICK_W-1:0]    res_wait_reg;
    logic [nps_pkg::TICK_W-1:0]    res_turn_reg;
    logic                          res_last_reg;

    logic                          has_room;
    logic [nps_pkg::ARR_W-1:0]     cur_arr;
    logic [nps_pkg::PRIO_W-1:0]    cur_prio;
    logic                          cur_pend;
    logic                          cur_arrived;
    logic                          cur_better;
    logic                          cur_earlier;

    assign has_room    = (count_reg < nps_pkg::CNT_W'(nps_pkg::MAX_PROCS));
    assign cur_arr     = arrival_store_reg[k_reg];
    assign cur_prio    = priority_store_reg[k_reg];
    assign cur_pend    = pend_reg[k_reg];
    assign cur_arrived = (nps_pkg::TICK_W'(cur_arr) <= tick_reg);
    assign cur_better  = cur_pend && cur_arrived && (!found_reg || (cur_prio < best_prio_reg));
    assign cur_earlier = cur_pend && (!any_reg || (cur_arr < earliest_reg));

    assign status.scan_last = (nps_pkg::CNT_W'(k_reg) == count_reg - nps_pkg::CNT_W'(1));
    assign status.found     = found_reg;
    assign status.final_job = res_last_reg;

    // job stores, selection payload and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load && has_room)
        begin
            burst_store_reg[count_reg[nps_pkg::IDX_W-1:0]]    <= burst_time;
            arrival_store_reg[count_reg[nps_pkg::IDX_W-1:0]]  <= arrival_time;
            priority_store_reg[count_reg[nps_pkg::IDX_W-1:0]] <= priority_level;
        end
        if (cmd.scan_step && cur_better)
        begin
            best_idx_reg   <= k_reg;
            best_prio_reg  <= cur_prio;
            best_arr_reg   <= cur_arr;
            best_burst_reg <= burst_store_reg[k_reg];
        end
        if (cmd.scan_step && cur_earlier)
            earliest_reg <= cur_arr;
        if (cmd.commit1)
        begin
            res_idx_reg  <= nps_pkg::JOB_IDX_W'(best_idx_reg);
            res_wait_reg <= tick_reg - nps_pkg::TICK_W'(best_arr_reg);
            res_last_reg <= ((done_reg + nps_pkg::CNT_W'(1)) == count_reg);
        end
        if (cmd.commit2)
            res_turn_reg <= tick_reg - nps_pkg::TICK_W'(best_arr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            count_reg <= '0;
            done_reg  <= '0;
            tick_reg  <= '0;
            wsum_reg  <= '0;
            tsum_reg  <= '0;
            drop_reg  <= 1'b0;
            k_reg     <= '0;
            found_reg <= 1'b0;
            any_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (has_room)
                begin
                    pend_reg[count_reg[nps_pkg::IDX_W-1:0]] <= 1'b1;
                    count_reg <= count_reg + nps_pkg::CNT_W'(1);
                end
                else
                    drop_reg <= 1'b1;
            end
            if (cmd.scan_init)
            begin
                k_reg     <= '0;
                found_reg <= 1'b0;
                any_reg   <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                k_reg <= k_reg + nps_pkg::IDX_W'(1);
                if (cur_better)
                    found_reg <= 1'b1;
                if (cur_pend)
                    any_reg <= 1'b1;
            end
            if (cmd.jump)
            begin
                tick_reg  <= nps_pkg::TICK_W'(earliest_reg);
                k_reg     <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.commit1)
            begin
                pend_reg[best_idx_reg] <= 1'b0;
                tick_reg <= tick_reg + nps_pkg::TICK_W'(best_burst_reg);
                done_reg <= done_reg + nps_pkg::CNT_W'(1);
            end
            if (cmd.commit2)
                wsum_reg <= wsum_reg + nps_pkg::SUM_W'(res_wait_reg);
            if (cmd.commit3)
                tsum_reg <= tsum_reg + nps_pkg::SUM_W'(res_turn_reg);
            if (cmd.clear)
            begin
                pend_reg  <= '0;
                count_reg <= '0;
                done_reg  <= '0;
                tick_reg  <= '0;
                wsum_reg  <= '0;
                tsum_reg  <= '0;
                drop_reg  <= 1'b0;
            end
        end
    end

    assign job_index       = res_idx_reg;
    assign wait_time       = res_wait_reg;
    assign turnaround_time = res_turn_reg;
    assign wait_sum        = wsum_reg;
    assign turnaround_sum  = tsum_reg;
    assign overflow        = drop_reg;
    assign last_result     = res_last_reg;

endmodule

/* rtl/nonpreemptive_priority_scheduler.sv */
// Non-preemptive priority scheduler, top level. Depends on nps_pkg, nps_job_if,
// nps_res_if, nps_ctrl and nps_datapath.
// Loading: one job request per cycle while idle; a job past capacity is dropped.
// Per result: a scan over the n stored jobs, a check state, three commit states and an output
// state that waits for out_ready, plus a jump and a rescan when the CPU must idle to the next arrival.
// Reset (async, active low) clears pending flags, counts, tick, sums and the drop flag.
module nonpreemptive_priority_scheduler (
    input logic       clk,
    input logic       rst_n,
    nps_job_if.sink   jobs,
    nps_res_if.source results
);

    nps_pkg::nps_cmd_t    cmd;
    nps_pkg::nps_status_t status;

    nps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (jobs.valid),
        .in_last   (jobs.last),
        .in_ready  (jobs.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    nps_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .burst_time      (jobs.burst_time),
        .arrival_time    (jobs.arrival_time),
        .priority_level  (jobs.priority_level),
        .job_index       (results.job_index),
        .wait_time       (results.wait_time),
        .turnaround_time (results.turnaround_time),
        .wait_sum        (results.wait_sum),
        .turnaround_sum  (results.turnaround_sum),
        .overflow        (results.overflow),
        .last_result     (results.last_result)
    );

endmodule

/* test/nonpreemptive_priority_scheduler_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for nonpreemptive_priority_scheduler: loads job sets, predicts
// the run order, wait and turnaround of every stored job, and checks each result request.
// Depends on nps_pkg, nps_job_if, nps_res_if and the scheduler RTL.
module nonpreemptive_priority_scheduler_tb;
    import nps_pkg::*;

    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [ARR_W-1:0]   arr;
        logic [PRIO_W-1:0]  prio;
        logic               last;
    } job_t;

    typedef struct packed {
        logic [JOB_IDX_W-1:0] job_index;
        logic [TICK_W-1:0]    wait_time;
        logic [TICK_W-1:0]    turnaround_time;
        logic [SUM_W-1:0]     wait_sum;
        logic [SUM_W-1:0]     turnaround_sum;
        logic                 overflow;
        logic                 last_result;
    } run_rec_t;

    class schedule_tracker;
        bit [BURST_W-1:0] burst_tab [MAX_PROCS];
        bit [ARR_W-1:0]   arr_tab   [MAX_PROCS];
        bit [PRIO_W-1:0]  prio_tab  [MAX_PROCS];
        bit               pend_tab  [MAX_PROCS];
        int               stored;
        bit               dropped;
        run_rec_t         run_order_q[$];
        int               mismatches;

        function new();
            stored     = 0;
            dropped    = 0;
            mismatches = 0;
            foreach (pend_tab[k]) pend_tab[k] = 0;
        endfunction

        function int outstanding();
            return run_order_q.size();
        endfunction

        function void run_schedule();
            bit [TICK_W-1:0]  tick;
            bit [TICK_W-1:0]  w;
            bit [TICK_W-1:0]  t;
            bit [SUM_W-1:0]   wsum;
            bit [SUM_W-1:0]   tsum;
            bit [ARR_W-1:0]   earliest;
            bit [PRIO_W-1:0]  best_prio;
            bit               found;
            bit               any;
            int               best;
            run_rec_t         r;
            tick = 0;
            wsum = 0;
            tsum = 0;
            for (int done = 0; done < stored; done++) begin
                found     = 0;
                any       = 0;
                best      = 0;
                best_prio = 0;
                earliest  = 0;
                for (int k = 0; k < stored; k++) begin
                    if (pend_tab[k]) begin
                        if (!any || arr_tab[k] < earliest)
                            earliest = arr_tab[k];
                        any = 1;
                        if (arr_tab[k] <= tick && (!found || prio_tab[k] < best_prio))
                        begin
                            best      = k;
                            best_prio = prio_tab[k];
                            found     = 1;
                        end
                    end
                end
                if (!found) begin
                    // CPU idles until the earliest pending arrival
                    tick = TICK_W'(earliest);
                    for (int k = 0; k < stored; k++) begin
                        if (pend_tab[k] && arr_tab[k] <= tick &&
                            (!found || prio_tab[k] < best_prio))
                        begin
                            best      = k;
                            best_prio = prio_tab[k];
                            found     = 1;
                        end
                    end
                end
                w = tick - TICK_W'(arr_tab[best]);
                pend_tab[best] = 0;
                tick = tick + TICK_W'(burst_tab[best]);
                t = tick - TICK_W'(arr_tab[best]);
                wsum = wsum + SUM_W'(w);
                tsum = tsum + SUM_W'(t);
                r.job_index       = best[JOB_IDX_W-1:0];
                r.wait_time       = w;
                r.turnaround_time = t;
                r.wait_sum        = wsum;
                r.turnaround_sum  = tsum;
                r.overflow        = dropped;
                r.last_result     = (done + 1 == stored);
                run_order_q.push_back(r);
            end
            foreach (pend_tab[k]) pend_tab[k] = 0;
            stored  = 0;
            dropped = 0;
        endfunction

        function void add_job(job_t j);
            if (stored < MAX_PROCS) begin
                burst_tab[stored] = j.burst;
                arr_tab[stored]   = j.arr;
                prio_tab[stored]  = j.prio;
                pend_tab[stored]  = 1;
                stored++;
            end
            else begin
                dropped = 1;
            end
            if (j.last)
                run_schedule();
        endfunction

        function void check_result(run_rec_t got);
            run_rec_t exp;
            if (run_order_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result job=%0d", $realtime, got.job_index);
                return;
            end
            exp = run_order_q.pop_front();
            if (got.job_index !== exp.job_index || got.wait_time !== exp.wait_time ||
                got.turnaround_time !== exp.turnaround_time ||
                got.wait_sum !== exp.wait_sum || got.turnaround_sum !== exp.turnaround_sum ||
                got.overflow !== exp.overflow || got.last_result !== exp.last_result)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch exp job=%0d wt=%0d tat=%0d ws=%0d ts=%0d ov=%0d ",
                              "lr=%0d got job=%0d wt=%0d tat=%0d ws=%0d ts=%0d ov=%0d lr=%0d"},
                             $realtime, exp.job_index, exp.wait_time, exp.turnaround_time,
                             exp.wait_sum, exp.turnaround_sum, exp.overflow, exp.last_result,
                             got.job_index, got.wait_time, got.turnaround_time,
                             got.wait_sum, got.turnaround_sum, got.overflow, got.last_result);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    nps_job_if jobs_if ();
    nps_res_if res_if ();

    nonpreemptive_priority_scheduler i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .jobs    (jobs_if),
        .results (res_if)
    );

    schedule_tracker tracker = new();

    bit src_idle_en;
    bit sink_idle_en;
    bit long_hold_req;
    int hold_left;
    int random_sent;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic job_t make_job(int b, int a, int p, bit l);
        job_t j;
        j.burst = BURST_W'(b);
        j.arr   = ARR_W'(a);
        j.prio  = PRIO_W'(p);
        j.last  = l;
        return j;
    endfunction

    function automatic job_t rand_job(bit l);
        job_t j;
        case ($urandom_range(0, 3))
            0: j.burst = BURST_W'($urandom_range(0, 20));
            1: j.burst = BURST_W'($urandom_range(0, 200));
            2: j.burst = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: j.burst = BURST_W'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 3))
            0: j.arr = ARR_W'($urandom_range(0, 10));
            1: j.arr = ARR_W'($urandom_range(0, 500));
            2: j.arr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: j.arr = ARR_W'($urandom_range(0, 65535));
        endcase
        j.prio = PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
        j.last = l;
        return j;
    endfunction

    // entered and left at a falling edge
    task automatic send_job(job_t j);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            jobs_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        jobs_if.valid          <= 1'b1;
        jobs_if.burst_time     <= j.burst;
        jobs_if.arrival_time   <= j.arr;
        jobs_if.priority_level <= j.prio;
        jobs_if.last           <= j.last;
        do @(posedge clk); while (!jobs_if.ready);
        tracker.add_job(j);
        @(negedge clk);
    endtask

    task automatic send_random_set(int size);
        for (int i = 0; i < size; i++) begin
            send_job(rand_job(i == size - 1));
            random_sent++;
        end
    endtask

    task automatic drain();
        while (tracker.outstanding() != 0) @(negedge clk);
    endtask

    // result side: ready changes at falling edges
    initial begin
        res_if.ready = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else if (long_hold_req) begin
                long_hold_req = 0;
                hold_left = 599;
                res_if.ready <= 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 6) == 0) begin
                hold_left = $urandom_range(1, 14) - 1;
                res_if.ready <= 1'b0;
            end
            else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        run_rec_t got;
        if (res_if.valid && res_if.ready) begin
            got.job_index       = res_if.job_index;
            got.wait_time       = res_if.wait_time;
            got.turnaround_time = res_if.turnaround_time;
            got.wait_sum        = res_if.wait_sum;
            got.turnaround_sum  = res_if.turnaround_sum;
            got.overflow        = res_if.overflow;
            got.last_result     = res_if.last_result;
            tracker.check_result(got);
        end
    end

    initial begin
        int size;
        jobs_if.valid          = 1'b0;
        jobs_if.burst_time     = '0;
        jobs_if.arrival_time   = '0;
        jobs_if.priority_level = '0;
        jobs_if.last           = 1'b0;
        rst_n         = 1'b0;
        src_idle_en   = 1'b0;
        sink_idle_en  = 1'b0;
        long_hold_req = 0;
        random_sent   = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single jobs at both extremes
        send_job(make_job(0, 0, 0, 1));
        send_job(make_job(65535, 65535, 255, 1));
        // equal priorities, all arrived: lowest index first
        send_job(make_job(5, 0, 3, 0));
        send_job(make_job(7, 0, 3, 0));
        send_job(make_job(2, 0, 3, 1));
        // mixed arrivals and a maximum burst: an arrived job is found at every decision
        send_job(make_job(10, 100, 9, 0));
        send_job(make_job(4, 0, 200, 0));
        send_job(make_job(3, 500, 0, 0));
        send_job(make_job(65535, 2, 1, 1));
        // one job past capacity is dropped
        for (int i = 0; i <= MAX_PROCS; i++)
            send_job(make_job($urandom_range(0, 30), $urandom_range(0, 40),
                              $urandom_range(0, 255), i == MAX_PROCS));
        drain();

        // long result hold-off while a full set and a set of 12 are offered
        long_hold_req = 1;
        send_random_set(MAX_PROCS);
        send_random_set(12);
        drain();

        while (random_sent < 100) begin
            if (random_sent >= 80) begin
                src_idle_en  = 0;
                sink_idle_en = 0;
            end
            else begin
                src_idle_en  = $urandom_range(0, 2) != 0;
                sink_idle_en = $urandom_range(0, 2) != 0;
            end
            case ($urandom_range(0, 9))
                0:       size = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 3);
                1, 2:    size = $urandom_range(7, MAX_PROCS);
                default: size = $urandom_range(1, 6);
            endcase
            send_random_set(size);
            if ($urandom_range(0, 5) == 0)
                drain();
        end
        jobs_if.valid <= 1'b0;

        drain();
        repeat (60) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
